/* hdl/hsvc_pkg.sv */
package hsvc_pkg;

   // default channel width; hue is Q0.CHAN_BITS, other channels are 0..2^B-1
   localparam int CHAN_BITS_DEF = 12;

   // stages beyond one per quotient bit: two front stages and the output stage
   localparam int PIPE_EXTRA = 3;

   // conversion direction carried with each word
   typedef enum logic {
      ACT_HSV2RGB = 1'b0,
      ACT_RGB2HSV = 1'b1
   } action_type;

   // which channel holds the maximum (ties go to red, then green)
   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_sel_type;

   // hue sector, floor(6h)
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

endpackage

/* hdl/hsvc_fwd.sv */
module hsvc_fwd
   import hsvc_pkg::*;
#(
   parameter int CHAN_BITS = CHAN_BITS_DEF,
   localparam int STAGES = CHAN_BITS + PIPE_EXTRA
) (
   input  logic                 clock,
   input  logic [STAGES-1:0]    adv,
   input  logic [CHAN_BITS-1:0] in_h,
   input  logic [CHAN_BITS-1:0] in_s,
   input  logic [CHAN_BITS-1:0] in_v,
   output logic [CHAN_BITS-1:0] out_r,
   output logic [CHAN_BITS-1:0] out_g,
   output logic [CHAN_BITS-1:0] out_b
);

   localparam int B = CHAN_BITS;
   localparam logic [B-1:0]   FULL    = '1;
   localparam logic [B:0]     HUE_ONE = {1'b1, {B{1'b0}}};
   localparam logic [2*B-1:0] DEN     = {FULL, {B{1'b0}}};

   // floor(y / FULL) for y < 2^(2B): y = q0*FULL + (lo + q0), lo + q0 <= 2*FULL
   function automatic logic [B-1:0] div_full(input logic [2*B-1:0] y);
      logic [B-1:0] q0;
      logic [B:0]   rem;
      logic         c1;
      logic         c2;
      q0  = y[2*B-1:B];
      rem = {1'b0, y[B-1:0]} + {1'b0, q0};
      c1  = rem >= {1'b0, FULL};
      c2  = rem >= {FULL, 1'b0};
      return q0 + B'(c1) + B'(c2);
   endfunction

   // stage 0: sector and fraction of 6h
   logic [B+2:0] h6;
   logic [B:0]   fc_w;
   sector_type   sec0_ff;
   logic [B-1:0] f0_ff, s0_ff, v0_ff;
   logic [B:0]   fc0_ff;

   assign h6   = {1'b0, in_h, 2'b00} + {2'b00, in_h, 1'b0};
   assign fc_w = HUE_ONE - {1'b0, h6[B-1:0]};

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec0_ff <= sector_type'(h6[B+2:B]);
         f0_ff   <= h6[B-1:0];
         fc0_ff  <= fc_w;
         s0_ff   <= in_s;
         v0_ff   <= in_v;
      end
   end

   // stage 1: saturation products
   logic [2*B-1:0] sf_w, pm_w;
   logic [2*B:0]   sfc_w;
   sector_type     sec1_ff;
   logic [B-1:0]   v1_ff;
   logic [2*B-1:0] sf1_ff, sfc1_ff, pm1_ff;

   assign sf_w  = s0_ff * f0_ff;
   assign sfc_w = {1'b0, s0_ff} * fc0_ff;
   assign pm_w  = v0_ff * (FULL - s0_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         sec1_ff <= sec0_ff;
         v1_ff   <= v0_ff;
         sf1_ff  <= sf_w;
         sfc1_ff <= sfc_w[2*B-1:0];
         pm1_ff  <= pm_w;
      end
   end

   // stage 2: complement against FULL*2^B, finish p
   sector_type     sec2_ff;
   logic [B-1:0]   v2_ff, p2_ff;
   logic [2*B-1:0] wq2_ff, wt2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sec2_ff <= sec1_ff;
         v2_ff   <= v1_ff;
         p2_ff   <= div_full(pm1_ff);
         wq2_ff  <= DEN - sf1_ff;
         wt2_ff  <= DEN - sfc1_ff;
      end
   end

   // stage 3: scale by value
   logic [3*B-1:0] mq_w, mt_w;
   sector_type     sec3_ff;
   logic [B-1:0]   v3_ff, p3_ff;
   logic [3*B-1:0] mq3_ff, mt3_ff;

   assign mq_w = v2_ff * wq2_ff;
   assign mt_w = v2_ff * wt2_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         sec3_ff <= sec2_ff;
         v3_ff   <= v2_ff;
         p3_ff   <= p2_ff;
         mq3_ff  <= mq_w;
         mt3_ff  <= mt_w;
      end
   end

   // stage 4: divide by FULL*2^B as shift then divide by FULL
   sector_type   sec4_ff;
   logic [B-1:0] v4_ff, p4_ff, q4_ff, t4_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         sec4_ff <= sec3_ff;
         v4_ff   <= v3_ff;
         p4_ff   <= p3_ff;
         q4_ff   <= div_full(mq3_ff[3*B-1:B]);
         t4_ff   <= div_full(mt3_ff[3*B-1:B]);
      end
   end

   // stage 5: route by sector, then delay to the output stage
   logic [3*B-1:0] pix_in;
   logic [3*B-1:0] pix_ff [5:STAGES-1];

   always_comb begin
      case (sec4_ff)
         SEC_RED_YEL: pix_in = {v4_ff, t4_ff, p4_ff};
         SEC_YEL_GRN: pix_in = {q4_ff, v4_ff, p4_ff};
         SEC_GRN_CYN: pix_in = {p4_ff, v4_ff, t4_ff};
         SEC_CYN_BLU: pix_in = {p4_ff, q4_ff, v4_ff};
         SEC_BLU_MAG: pix_in = {t4_ff, p4_ff, v4_ff};
         // magenta to red
         default:     pix_in = {v4_ff, p4_ff, q4_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         pix_ff[5] <= pix_in;
      end
   end

   for (genvar k = 6; k < STAGES; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            pix_ff[k] <= pix_ff[k-1];
         end
      end
   end

   assign out_r = pix_ff[STAGES-1][3*B-1:2*B];
   assign out_g = pix_ff[STAGES-1][2*B-1:B];
   assign out_b = pix_ff[STAGES-1][B-1:0];

endmodule

/* hdl/hsvc_inv.sv */
module hsvc_inv
   import hsvc_pkg::*;
#(
   parameter int CHAN_BITS = CHAN_BITS_DEF,
   localparam int STAGES = CHAN_BITS + PIPE_EXTRA
) (
   input  logic                 clock,
   input  logic [STAGES-1:0]    adv,
   input  logic [CHAN_BITS-1:0] in_r,
   input  logic [CHAN_BITS-1:0] in_g,
   input  logic [CHAN_BITS-1:0] in_b,
   output logic [CHAN_BITS-1:0] out_h,
   output logic [CHAN_BITS-1:0] out_s,
   output logic [CHAN_BITS-1:0] out_v
);

   localparam int B       = CHAN_BITS;
   localparam int W3      = B + 3;
   localparam int REM_H_W = 2*B + 3;
   localparam int REM_S_W = 2*B;

   // stage 0: max, min, spread
   max_sel_type  msel_w;
   logic [B-1:0] mx_w, mn_w;
   max_sel_type  msel0_ff;
   logic [B-1:0] mx0_ff, d0_ff, r0_ff, g0_ff, b0_ff;

   always_comb begin
      if (in_r >= in_g && in_r >= in_b) begin
         msel_w = MAX_RED;
         mx_w   = in_r;
      end else if (in_g >= in_b) begin
         msel_w = MAX_GREEN;
         mx_w   = in_g;
      end else begin
         msel_w = MAX_BLUE;
         mx_w   = in_b;
      end
      mn_w = in_r;
      if (in_g < mn_w) mn_w = in_g;
      if (in_b < mn_w) mn_w = in_b;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         msel0_ff <= msel_w;
         mx0_ff   <= mx_w;
         d0_ff    <= mx_w - mn_w;
         r0_ff    <= in_r;
         g0_ff    <= in_g;
         b0_ff    <= in_b;
      end
   end

   // stage 1: hue numerator and divisors
   logic [W3-1:0] d6_w, n_w, r_x, g_x, b_x;

   assign d6_w = {1'b0, d0_ff, 2'b00} + {2'b00, d0_ff, 1'b0};
   assign r_x  = {3'b000, r0_ff};
   assign g_x  = {3'b000, g0_ff};
   assign b_x  = {3'b000, b0_ff};

   always_comb begin
      case (msel0_ff)
         MAX_RED:   n_w = (g0_ff >= b0_ff) ? (g_x - b_x) : (d6_w + g_x - b_x);
         MAX_GREEN: n_w = b_x + {2'b00, d0_ff, 1'b0} - r_x;
         default:   n_w = r_x + {1'b0, d0_ff, 2'b00} - g_x;
      endcase
   end

   // divider pipeline, one quotient bit per stage; index 0 is the stage 1 register
   logic [REM_H_W-1:0] remh_ff [0:B-1];
   logic [W3-1:0]      dh_ff   [0:B-1];
   logic [REM_S_W-1:0] rems_ff [0:B-1];
   logic [B-1:0]       ds_ff   [0:B-1];
   logic [B-1:0]       qh_ff   [1:B];
   logic [B-1:0]       qs_ff   [1:B];
   logic [B-1:0]       v_ff    [0:B];
   logic               hz_ff   [0:B];
   logic               sz_ff   [0:B];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         remh_ff[0] <= {n_w, {B{1'b0}}};
         dh_ff[0]   <= d6_w;
         rems_ff[0] <= {d0_ff, {B{1'b0}}} - {{B{1'b0}}, d0_ff};
         ds_ff[0]   <= mx0_ff;
         v_ff[0]    <= mx0_ff;
         hz_ff[0]   <= (d0_ff == '0);
         sz_ff[0]   <= (mx0_ff == '0);
      end
   end

   for (genvar j = 0; j < B; j++) begin : g_div
      localparam int K = B - 1 - j;
      logic [REM_H_W-1:0] dsh;
      logic [REM_S_W-1:0] dss;
      logic               geh, ges;
      logic [B-1:0]       qh_in, qs_in;

      // trial subtract of the divisor at bit K
      assign dsh = REM_H_W'(dh_ff[j]) << K;
      assign dss = REM_S_W'(ds_ff[j]) << K;
      assign geh = remh_ff[j] >= dsh;
      assign ges = rems_ff[j] >= dss;

      if (j == 0) begin : g_first
         assign qh_in = {{(B-1){1'b0}}, geh};
         assign qs_in = {{(B-1){1'b0}}, ges};
      end else begin : g_next
         assign qh_in = {qh_ff[j][B-2:0], geh};
         assign qs_in = {qs_ff[j][B-2:0], ges};
      end

      always_ff @(posedge clock) begin
         if (adv[j+2]) begin
            qh_ff[j+1] <= qh_in;
            qs_ff[j+1] <= qs_in;
            v_ff[j+1]  <= v_ff[j];
            hz_ff[j+1] <= hz_ff[j];
            sz_ff[j+1] <= sz_ff[j];
         end
      end

      if (j < B - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv[j+2]) begin
               remh_ff[j+1] <= geh ? (remh_ff[j] - dsh) : remh_ff[j];
               rems_ff[j+1] <= ges ? (rems_ff[j] - dss) : rems_ff[j];
               dh_ff[j+1]   <= dh_ff[j];
               ds_ff[j+1]   <= ds_ff[j];
            end
         end
      end
   end

   // output stage: zero spread gives hue 0, zero max gives saturation 0
   logic [B-1:0] h_ff, s_ff, vo_ff;

   always_ff @(posedge clock) begin
      if (adv[STAGES-1]) begin
         h_ff  <= hz_ff[B] ? '0 : qh_ff[B];
         s_ff  <= sz_ff[B] ? '0 : qs_ff[B];
         vo_ff <= v_ff[B];
      end
   end

   assign out_h = h_ff;
   assign out_s = s_ff;
   assign out_v = vo_ff;

endmodule

/* hdl/hsv_rgb_color_converter.sv */
// HSV <-> RGB pixel converter, both directions in one pipeline.
// The pipeline has CHAN_BITS + 3 register stages, and rsp_valid is taken from the last.
// It takes one word per cycle while req_stall is low; depth is set by the RGB to HSV
// divider, which resolves one quotient bit per stage.
// Reset clears the stage valid bits only; data registers are not reset.
module hsv_rgb_color_converter
   import hsvc_pkg::*;
#(
   parameter int CHAN_BITS = CHAN_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [CHAN_BITS-1:0] req_chan_x,
   input  logic [CHAN_BITS-1:0] req_chan_y,
   input  logic [CHAN_BITS-1:0] req_chan_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CHAN_BITS-1:0] rsp_res_x,
   output logic [CHAN_BITS-1:0] rsp_res_y,
   output logic [CHAN_BITS-1:0] rsp_res_z
);

   localparam int STAGES = CHAN_BITS + PIPE_EXTRA;

   logic [STAGES-1:0] adv;
   logic [STAGES-1:0] vld_ff, vld_in;
   action_type        act_ff [0:STAGES-1];

   // a stage moves when it is empty or the stage after it moves
   assign adv[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
   for (genvar k = 0; k < STAGES - 1; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // direction travels beside the data
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         act_ff[0] <= action_type'(req_action);
      end
   end

   for (genvar k = 1; k < STAGES; k++) begin : g_act
      always_ff @(posedge clock) begin
         if (adv[k]) begin
            act_ff[k] <= act_ff[k-1];
         end
      end
   end

   logic [CHAN_BITS-1:0] fwd_r, fwd_g, fwd_b;
   logic [CHAN_BITS-1:0] inv_h, inv_s, inv_v;

   hsvc_fwd #(
      .CHAN_BITS (CHAN_BITS)
   ) u_fwd (
      .clock (clock),
      .adv   (adv),
      .in_h  (req_chan_x),
      .in_s  (req_chan_y),
      .in_v  (req_chan_z),
      .out_r (fwd_r),
      .out_g (fwd_g),
      .out_b (fwd_b)
   );

   hsvc_inv #(
      .CHAN_BITS (CHAN_BITS)
   ) u_inv (
      .clock (clock),
      .adv   (adv),
      .in_r  (req_chan_x),
      .in_g  (req_chan_y),
      .in_b  (req_chan_z),
      .out_h (inv_h),
      .out_s (inv_s),
      .out_v (inv_v)
   );

   // pick the finished result for this word's direction
   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[STAGES-1];
   assign rsp_res_x = (act_ff[STAGES-1] == ACT_RGB2HSV) ? inv_h : fwd_r;
   assign rsp_res_y = (act_ff[STAGES-1] == ACT_RGB2HSV) ? inv_s : fwd_g;
   assign rsp_res_z = (act_ff[STAGES-1] == ACT_RGB2HSV) ? inv_v : fwd_b;

endmodule
